// File: rtl/message_id_table_lookup_macros.svh
// assertion macros used by the checker file
`ifndef MESSAGE_ID_TABLE_LOOKUP_MACROS_SVH
`define MESSAGE_ID_TABLE_LOOKUP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MITL_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define MITL_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mitl_pkg.sv
// shared types and constants for the message id table lookup
package mitl_pkg;

  localparam int unsigned ID_W       = 32;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned FORM_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  // item function codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // id form codes
  localparam logic [FORM_W-1:0] FORM_LOWER = 3'd0;
  localparam logic [FORM_W-1:0] FORM_24_8  = 3'd1;
  localparam logic [FORM_W-1:0] FORM_16_16 = 3'd2;
  localparam logic [FORM_W-1:0] FORM_8_24  = 3'd3;
  localparam logic [FORM_W-1:0] FORM_UPPER = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_PRESENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_FORM       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IS_ORDERED    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT   = 2'd3;

  localparam logic [ID_W-1:0] ALL_ONES_ID = 32'hFFFF_FFFF;
  localparam logic [ID_W-1:0] MASK24      = 32'h00FF_FFFF;
  localparam logic [ID_W-1:0] MASK16      = 32'h0000_FFFF;
  localparam logic [ID_W-1:0] MASK8       = 32'h0000_00FF;
  localparam logic [ID_W-1:0] HI_MASK8    = 32'hFF00_0000;
  localparam logic [ID_W-1:0] HI_MASK16   = 32'hFFFF_0000;
  localparam logic [ID_W-1:0] HI_MASK24   = 32'hFFFF_FF00;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] entry_index;
    logic [ID_W-1:0]  entry_value;
    logic [ID_W-1:0]  lower_half;
    logic [ID_W-1:0]  upper_half;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] msg_index;
    logic             found;
    logic             halves_fit;
    logic             fit_reported;
  } out_word_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            fit;
    logic            form_ok;
  } pack_res_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

// File: rtl/message_id_table_lookup.sv
// message id table lookup: table ram, search sequencer and result register
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in_     | in        | in_valid / in_ready   | in_data  (write or lookup word)
//   out_    | out       | out_valid / out_ready | out_data (one result per word)
//   cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a write word or a lookup that needs no search goes from idle straight to the done state,
// then into the output register; a linear scan reads the table entries in order (up to
// entry_count, at most TABLE_DEPTH); an ordered search reads one probe at a time, about
// log2(n)+1 probes, plus a final equality read; the single ram read port sets the pace.
// reset clears control and configuration only; the table is undefined until written.
// in_ready is high only when the sequencer is idle; a finished result waits in the
// output register while the next word is taken, and the sequencer stalls only when it
// has another result and that register is still full.
module message_id_table_lookup #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mitl_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mitl_pkg::out_word_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mitl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mitl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = mitl_pkg::COUNT_W;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_FINAL = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic                          table_present_r;
  logic [mitl_pkg::FORM_W-1:0]   id_form_r;
  logic                          is_ordered_r;
  logic [CW-1:0]                 entry_count_r;

  // search state
  logic [mitl_pkg::ID_W-1:0] id_r, id_nxt;
  logic [CW-1:0]             lo_r, lo_nxt;
  logic [CW-1:0]             len_r, len_nxt;
  logic [CW-1:0]             probe_r, probe_nxt;
  mitl_pkg::out_word_t       res_r, res_nxt;

  // output register
  logic                      out_valid_r;
  mitl_pkg::out_word_t       out_data_r;

  logic                      in_acc;
  logic                      out_load;
  logic [CW-1:0]             n_lim;
  logic [CW-1:0]             half;
  logic [CW-1:0]             lo_step;
  logic [CW-1:0]             len_step;
  logic [CW-1:0]             pos_inc;
  logic                      wr_in_range;
  logic                      wr_en;
  logic                      rd_en;
  logic [CW-1:0]             rd_pos;
  logic [AW+CW-1:0]          rd_ext;
  logic [AW+mitl_pkg::IDX_W-1:0] wr_ext;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  logic [mitl_pkg::ID_W-1:0] rd_data;
  mitl_pkg::pack_res_t       pk;
  mitl_pkg::cmp_res_t        cmp;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // entry_count saturates at the table depth
  assign n_lim = (32'(entry_count_r) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : entry_count_r;

  assign wr_in_range = (32'(in_data.entry_index) < 32'(TABLE_DEPTH));
  assign wr_ext      = (AW + mitl_pkg::IDX_W)'(in_data.entry_index);
  assign wr_addr     = wr_ext[AW-1:0];
  assign rd_ext      = (AW + CW)'(rd_pos);
  assign rd_addr     = rd_ext[AW-1:0];

  // lower-bound step on the word just read
  assign half     = len_r >> 1;
  assign lo_step  = cmp.lt ? (probe_r + CW'(1)) : lo_r;
  assign len_step = cmp.lt ? (len_r - half - CW'(1)) : half;
  assign pos_inc  = probe_r + CW'(1);

  mitl_pack u_pack (
    .form       (id_form_r),
    .lower_half (in_data.lower_half),
    .upper_half (in_data.upper_half),
    .res        (pk)
  );

  mitl_cmp u_cmp (
    .entry (rd_data),
    .key   (id_r),
    .res   (cmp)
  );

  mitl_tbl #(
    .DEPTH (TABLE_DEPTH)
  ) u_tbl (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.entry_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    id_nxt    = id_r;
    lo_nxt    = lo_r;
    len_nxt   = len_r;
    probe_nxt = probe_r;
    res_nxt   = res_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_pos    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt   = '0;
          id_nxt    = pk.id;
          state_nxt = ST_DONE;
          if (in_data.func == mitl_pkg::FUNC_WRITE) begin
            wr_en = wr_in_range;
          end else if (table_present_r && pk.form_ok) begin
            res_nxt.halves_fit   = pk.fit;
            res_nxt.fit_reported = 1'b1;
            // the all-ones id and an empty table never hit
            if ((pk.id != mitl_pkg::ALL_ONES_ID) && (n_lim != '0)) begin
              state_nxt = ST_PROBE;
              rd_en     = 1'b1;
              if (is_ordered_r) begin
                lo_nxt    = '0;
                len_nxt   = n_lim;
                rd_pos    = n_lim >> 1;
                probe_nxt = n_lim >> 1;
              end else begin
                rd_pos    = '0;
                probe_nxt = '0;
              end
            end
          end
        end
      end
      ST_PROBE: begin
        if (is_ordered_r) begin
          lo_nxt  = lo_step;
          len_nxt = len_step;
          if (len_step != '0) begin
            rd_en     = 1'b1;
            rd_pos    = lo_step + (len_step >> 1);
            probe_nxt = lo_step + (len_step >> 1);
          end else if (lo_step < n_lim) begin
            // lower bound settled, read it once more for the equality test
            rd_en     = 1'b1;
            rd_pos    = lo_step;
            probe_nxt = lo_step;
            state_nxt = ST_FINAL;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          if (cmp.eq) begin
            res_nxt.found     = 1'b1;
            res_nxt.msg_index = probe_r[mitl_pkg::IDX_W-1:0];
            state_nxt         = ST_DONE;
          end else if (pos_inc < n_lim) begin
            rd_en     = 1'b1;
            rd_pos    = pos_inc;
            probe_nxt = pos_inc;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_FINAL: begin
        if (cmp.eq) begin
          res_nxt.found     = 1'b1;
          res_nxt.msg_index = probe_r[mitl_pkg::IDX_W-1:0];
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // search datapath, no reset needed
  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    lo_r    <= lo_nxt;
    len_r   <= len_nxt;
    probe_r <= probe_nxt;
    res_r   <= res_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_present_r <= 1'b0;
      id_form_r       <= '0;
      is_ordered_r    <= 1'b0;
      entry_count_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mitl_pkg::CFG_TABLE_PRESENT: table_present_r <= cfg_data[0];
        mitl_pkg::CFG_ID_FORM:       id_form_r       <= cfg_data[mitl_pkg::FORM_W-1:0];
        mitl_pkg::CFG_IS_ORDERED:    is_ordered_r    <= cfg_data[0];
        mitl_pkg::CFG_ENTRY_COUNT:   entry_count_r   <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // output register parts the sequencer from the result channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

endmodule

// File: rtl/mitl_pack.sv
// packs the two halves of a lookup into one id and checks that they fit
module mitl_pack (
  input  logic [mitl_pkg::FORM_W-1:0] form,
  input  logic [mitl_pkg::ID_W-1:0]   lower_half,
  input  logic [mitl_pkg::ID_W-1:0]   upper_half,
  output mitl_pkg::pack_res_t         res
);

  always_comb begin
    res = '0;
    unique case (form)
      mitl_pkg::FORM_LOWER: begin
        res.id      = lower_half;
        res.fit     = (upper_half == '0);
        res.form_ok = 1'b1;
      end
      mitl_pkg::FORM_24_8: begin
        res.id      = ((lower_half & mitl_pkg::MASK24) << 8) | (upper_half & mitl_pkg::MASK8);
        res.fit     = ((lower_half & mitl_pkg::HI_MASK8) == '0)
                   && ((upper_half & mitl_pkg::HI_MASK24) == '0);
        res.form_ok = 1'b1;
      end
      mitl_pkg::FORM_16_16: begin
        res.id      = ((lower_half & mitl_pkg::MASK16) << 16) | (upper_half & mitl_pkg::MASK16);
        res.fit     = ((lower_half & mitl_pkg::HI_MASK16) == '0)
                   && ((upper_half & mitl_pkg::HI_MASK16) == '0);
        res.form_ok = 1'b1;
      end
      mitl_pkg::FORM_8_24: begin
        res.id      = ((lower_half & mitl_pkg::MASK8) << 24) | (upper_half & mitl_pkg::MASK24);
        res.fit     = ((lower_half & mitl_pkg::HI_MASK24) == '0)
                   && ((upper_half & mitl_pkg::HI_MASK8) == '0);
        res.form_ok = 1'b1;
      end
      mitl_pkg::FORM_UPPER: begin
        res.id      = upper_half;
        res.fit     = (lower_half == '0);
        res.form_ok = 1'b1;
      end
      // unused form codes: not found, nothing reported
      default: res = '0;
    endcase
  end

endmodule

// File: rtl/mitl_cmp.sv
// shared 32-bit compare unit used by both search modes
module mitl_cmp (
  input  logic [mitl_pkg::ID_W-1:0] entry,
  input  logic [mitl_pkg::ID_W-1:0] key,
  output mitl_pkg::cmp_res_t        res
);

  assign res.lt = (entry < key);
  assign res.eq = (entry == key);

endmodule

// File: rtl/mitl_tbl.sv
// id table ram, one write port and one registered read port
module mitl_tbl #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [mitl_pkg::ID_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [mitl_pkg::ID_W-1:0] rd_data
);

  logic [mitl_pkg::ID_W-1:0] mem [DEPTH];
  logic [mitl_pkg::ID_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/mitl_chk.sv
// port checker for the message id table lookup, bound to the top level
`include "message_id_table_lookup_macros.svh"

module mitl_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input mitl_pkg::in_word_t              in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input mitl_pkg::out_word_t             out_data,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [mitl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [mitl_pkg::CFG_DATA_W-1:0] cfg_data
);

  // a stalled result word holds
  `MITL_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word dropped or changed while stalled")

  // every word leaves the idle state when taken, so ready drops after a take
  `MITL_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "input taken on back-to-back cycles")

  // no fit report means a write or an unusable lookup: all-zero result
  `MITL_IMPLIES(a_zero_result, out_valid && !out_data.fit_reported, !out_data.found && !out_data.halves_fit && (out_data.msg_index == '0), "unreported fit with non-zero result")

  // a miss reports index zero
  `MITL_IMPLIES(a_miss_index, out_valid && !out_data.found, out_data.msg_index == '0, "miss with non-zero index")

endmodule

bind message_id_table_lookup mitl_chk u_mitl_chk (.*);
